/* hdl/regime_window_dwell_tracker_assert.svh */
// ----------------------------------------------------------------------------
// Regime window dwell tracker assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef REGIME_WINDOW_DWELL_TRACKER_ASSERT_SVH
`define REGIME_WINDOW_DWELL_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define RWDT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RWDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RWDT_ASSERT(lbl, clk, rst, prop, msg)
`define RWDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/rwdt_pkg.sv */
// ----------------------------------------------------------------------------
// Regime window dwell tracker package
// Payload structs, register indexes, codes and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package rwdt_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int TIME_W     = 32;
   localparam int COUNT_W    = 32;
   localparam int ACC_W      = 48;
   localparam int LIMIT_W    = 48;
   localparam int CHANNELS   = 3;
   localparam int RULE_COUNT = 3;
   localparam int MASK_W     = 3;
   localparam int DWELL_W    = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int DIV_STEPS  = ACC_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMITS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIMITS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_ACTIVE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_ENABLE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_ENABLE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DWELL   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_METRIC_MODE = 3'd6;

   localparam logic [MODE_W-1:0] MODE_AVERAGE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PEAK    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MIN     = 2'd2;

   localparam logic KIND_INTERVAL = 1'b0;
   localparam logic KIND_SUMMARY  = 1'b1;

   localparam logic [DWELL_W-1:0] MIN_DWELL_RESET = 16'd500;

   typedef struct packed {
      logic [TIME_W-1:0]          time_ms;
      logic signed [SAMPLE_W-1:0] sample_a;
      logic signed [SAMPLE_W-1:0] sample_b;
      logic signed [SAMPLE_W-1:0] sample_c;
      logic [MASK_W-1:0]          sample_valid_mask;
      logic signed [SAMPLE_W-1:0] metric_sample;
      logic                       metric_valid;
      logic                       in_range;
      logic                       end_of_log;
   } req_payload_type;

   typedef struct packed {
      logic                       record_kind;
      logic [TIME_W-1:0]          start_time;
      logic [TIME_W-1:0]          end_time;
      logic [COUNT_W-1:0]         matched_rows;
      logic signed [SAMPLE_W-1:0] metric_result;
      logic [TIME_W-1:0]          total_dwell_ms;
      logic                       regime_seen;
      logic                       last;
   } rsp_payload_type;

   typedef struct packed {
      logic row_load;
      logic eval;
      logic close;
      logic report;
      logic div_load;
      logic div_step;
      logic summary;
   } ctrl_cmd_type;

   typedef struct packed {
      logic close_needed;
      logic end_of_log;
      logic report_ok;
      logic avg_needed;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* hdl/rwdt_ctrl.sv */
// ----------------------------------------------------------------------------
// Regime window dwell tracker controller
// Sequences row evaluation, run close, interval report, average divide and
// end-of-log summary.
// ----------------------------------------------------------------------------
`default_nettype none
`include "regime_window_dwell_tracker_assert.svh"

module rwdt_ctrl import rwdt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_EVAL    = 7'b0000010,
      ST_CLOSE   = 7'b0000100,
      ST_REPORT  = 7'b0001000,
      ST_FINISH  = 7'b0010000,
      ST_DIVIDE  = 7'b0100000,
      ST_SUMMARY = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.row_load = 1'b1;
               state_in     = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (status.close_needed) begin
               state_in = ST_CLOSE;
            end else if (status.end_of_log) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = ST_REPORT;
         end
         ST_REPORT: begin
            // short or backward runs are dropped without a record
            if (status.report_ok) begin
               if (status.out_free) begin
                  cmd.report = 1'b1;
                  state_in   = status.end_of_log ? ST_FINISH : ST_IDLE;
               end
            end else begin
               state_in = status.end_of_log ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (status.avg_needed) begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIVIDE;
            end else begin
               state_in = ST_SUMMARY;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SUMMARY;
            end
         end
         ST_SUMMARY: begin
            if (status.out_free) begin
               cmd.summary = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   `RWDT_ASSERT_NEXT(a_accept_eval, clock, reset, state_ff == ST_IDLE && req_valid, state_ff == ST_EVAL, "accepted row not evaluated")
   `RWDT_ASSERT_NEXT(a_close_report, clock, reset, state_ff == ST_CLOSE, state_ff == ST_REPORT, "run close not followed by report")
   `RWDT_ASSERT_NEXT(a_divide_hold, clock, reset, state_ff == ST_DIVIDE && !status.div_last, state_ff == ST_DIVIDE, "divide left early")

endmodule

`default_nettype wire

/* hdl/rwdt_datapath.sv */
// ----------------------------------------------------------------------------
// Regime window dwell tracker datapath
// Config registers, row match, run and metric state, radix-2 divider and
// output record register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "regime_window_dwell_tracker_assert.svh"

module rwdt_datapath import rwdt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  req_payload_type      req_payload,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output rsp_payload_type      rsp_payload
);

   // config
   logic [LIMIT_W-1:0] low_limits_ff;
   logic [LIMIT_W-1:0] high_limits_ff;
   logic [MASK_W-1:0]  rule_active_ff;
   logic [MASK_W-1:0]  low_enable_ff;
   logic [MASK_W-1:0]  high_enable_ff;
   logic [DWELL_W-1:0] min_dwell_ff;
   logic [MODE_W-1:0]  metric_mode_ff;

   // tracking state
   req_payload_type           row_ff;
   logic                      run_open_ff, run_open_in;
   logic [TIME_W-1:0]         run_start_ff, run_start_in;
   logic [COUNT_W-1:0]        row_count_ff, row_count_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic                      seen_ff, seen_in;
   logic [TIME_W-1:0]         dwell_ff, dwell_in;
   logic [TIME_W-1:0]         dur_ff;
   logic                      borrow_ff;

   // divider
   logic [ACC_W-1:0]          quot_ff, quot_in;
   logic [COUNT_W-1:0]        rem_ff, rem_in;
   logic                      neg_ff;
   logic [DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;

   // output
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic signed [SAMPLE_W-1:0] samp [CHANNELS];
   logic                       row_match;
   logic                       metric_avg;
   logic                       out_free;
   logic signed [ACC_W:0]      acc_sum;
   logic signed [ACC_W-1:0]    metric_ext;
   logic [ACC_W-1:0]           acc_mag;
   logic [TIME_W:0]            close_diff;
   logic [TIME_W:0]            dwell_sum;
   logic                       report_ok;
   logic [COUNT_W+1:0]         div_trial;
   logic signed [SAMPLE_W-1:0] metric_result;

   assign samp[0] = row_ff.sample_a;
   assign samp[1] = row_ff.sample_b;
   assign samp[2] = row_ff.sample_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limits_ff  <= '0;
         high_limits_ff <= '0;
         rule_active_ff <= '0;
         low_enable_ff  <= '0;
         high_enable_ff <= '0;
         min_dwell_ff   <= MIN_DWELL_RESET;
         metric_mode_ff <= MODE_AVERAGE;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LOW_LIMITS:  low_limits_ff  <= csr_data;
            CSR_HIGH_LIMITS: high_limits_ff <= csr_data;
            CSR_RULE_ACTIVE: rule_active_ff <= csr_data[MASK_W-1:0];
            CSR_LOW_ENABLE:  low_enable_ff  <= csr_data[MASK_W-1:0];
            CSR_HIGH_ENABLE: high_enable_ff <= csr_data[MASK_W-1:0];
            CSR_MIN_DWELL:   min_dwell_ff   <= csr_data[DWELL_W-1:0];
            CSR_METRIC_MODE: metric_mode_ff <= csr_data[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // every active rule needs a valid sample inside its enabled bounds
   always_comb begin
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] hi;
      row_match = 1'b1;
      for (int i = 0; i < RULE_COUNT; i++) begin
         lo = $signed(low_limits_ff[i*SAMPLE_W +: SAMPLE_W]);
         hi = $signed(high_limits_ff[i*SAMPLE_W +: SAMPLE_W]);
         if (rule_active_ff[i]) begin
            if (!row_ff.sample_valid_mask[i]) begin
               row_match = 1'b0;
            end
            if (low_enable_ff[i] && (samp[i] < lo)) begin
               row_match = 1'b0;
            end
            if (high_enable_ff[i] && (samp[i] > hi)) begin
               row_match = 1'b0;
            end
         end
      end
   end

   assign metric_avg = (metric_mode_ff != MODE_PEAK) && (metric_mode_ff != MODE_MIN);
   assign metric_ext = ACC_W'(row_ff.metric_sample);
   assign acc_sum    = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(row_ff.metric_sample);
   assign close_diff = {1'b0, row_ff.time_ms} - {1'b0, run_start_ff};
   assign dwell_sum  = {1'b0, dwell_ff} + {1'b0, dur_ff};
   assign report_ok  = !borrow_ff && (dur_ff >= {{(TIME_W-DWELL_W){1'b0}}, min_dwell_ff});
   assign acc_mag    = acc_ff[ACC_W-1] ? (~acc_ff[ACC_W-1:0] + {{(ACC_W-1){1'b0}}, 1'b1})
                                       : acc_ff[ACC_W-1:0];
   assign div_trial  = {1'b0, rem_ff, quot_ff[ACC_W-1]} - {2'b00, row_count_ff};

   always_comb begin
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      row_count_in = row_count_ff;
      acc_in       = acc_ff;
      seen_in      = seen_ff;
      dwell_in     = dwell_ff;
      if (cmd.eval && row_ff.in_range && row_match) begin
         if (!run_open_ff) begin
            run_open_in  = 1'b1;
            run_start_in = row_ff.time_ms;
         end
         if (row_count_ff != '1) begin
            row_count_in = row_count_ff + {{(COUNT_W-1){1'b0}}, 1'b1};
         end
         if (row_ff.metric_valid) begin
            seen_in = 1'b1;
            if (metric_mode_ff == MODE_PEAK) begin
               if (!seen_ff || (metric_ext > acc_ff)) begin
                  acc_in = metric_ext;
               end
            end else if (metric_mode_ff == MODE_MIN) begin
               if (!seen_ff || (metric_ext < acc_ff)) begin
                  acc_in = metric_ext;
               end
            end else if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
               // signed saturation of the running sum
               acc_in = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end else begin
               acc_in = acc_sum[ACC_W-1:0];
            end
         end
      end
      if (cmd.close) begin
         run_open_in = 1'b0;
      end
      if (cmd.report) begin
         dwell_in = dwell_sum[TIME_W] ? '1 : dwell_sum[TIME_W-1:0];
      end
      if (cmd.summary) begin
         run_open_in  = 1'b0;
         run_start_in = '0;
         row_count_in = '0;
         acc_in       = '0;
         seen_in      = 1'b0;
         dwell_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff  <= 1'b0;
         run_start_ff <= '0;
         row_count_ff <= '0;
         acc_ff       <= '0;
         seen_ff      <= 1'b0;
         dwell_ff     <= '0;
      end else begin
         run_open_ff  <= run_open_in;
         run_start_ff <= run_start_in;
         row_count_ff <= row_count_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         dwell_ff     <= dwell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.row_load) begin
         row_ff <= req_payload;
      end
      if (cmd.close) begin
         dur_ff    <= close_diff[TIME_W-1:0];
         borrow_ff <= close_diff[TIME_W];
      end
   end

   // restoring divide of |sum| by row count, one quotient bit per cycle
   always_comb begin
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_load) begin
         quot_in    = acc_mag;
         rem_in     = '0;
         div_cnt_in = DIV_CNT_W'(DIV_STEPS);
      end else if (cmd.div_step) begin
         div_cnt_in = div_cnt_ff - {{(DIV_CNT_W-1){1'b0}}, 1'b1};
         if (!div_trial[COUNT_W+1]) begin
            rem_in  = div_trial[COUNT_W-1:0];
            quot_in = {quot_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[COUNT_W-2:0], quot_ff[ACC_W-1]};
            quot_in = {quot_ff[ACC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else begin
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (cmd.div_load) begin
         neg_ff <= acc_ff[ACC_W-1];
      end
   end

   always_comb begin
      if (!metric_avg) begin
         if (!seen_ff) begin
            metric_result = '0;
         end else if (acc_ff > ACC_W'(32767)) begin
            metric_result = 16'sh7FFF;
         end else if (acc_ff < -ACC_W'(32768)) begin
            metric_result = 16'sh8000;
         end else begin
            metric_result = acc_ff[SAMPLE_W-1:0];
         end
      end else if (row_count_ff == '0) begin
         metric_result = '0;
      end else if (neg_ff) begin
         if (quot_ff > ACC_W'(32768)) begin
            metric_result = 16'sh8000;
         end else begin
            metric_result = $signed(~quot_ff[SAMPLE_W-1:0] + 16'd1);
         end
      end else if (quot_ff > ACC_W'(32767)) begin
         metric_result = 16'sh7FFF;
      end else begin
         metric_result = $signed(quot_ff[SAMPLE_W-1:0]);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (cmd.report) begin
         rsp_valid_in                  = 1'b1;
         rsp_payload_in                = '0;
         rsp_payload_in.record_kind    = KIND_INTERVAL;
         rsp_payload_in.start_time     = run_start_ff;
         rsp_payload_in.end_time       = row_ff.time_ms;
         rsp_payload_in.last           = !row_ff.end_of_log;
      end else if (cmd.summary) begin
         rsp_valid_in                  = 1'b1;
         rsp_payload_in                = '0;
         rsp_payload_in.record_kind    = KIND_SUMMARY;
         rsp_payload_in.matched_rows   = row_count_ff;
         rsp_payload_in.metric_result  = metric_result;
         rsp_payload_in.total_dwell_ms = dwell_ff;
         rsp_payload_in.regime_seen    = (dwell_ff != '0);
         rsp_payload_in.last           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign status.close_needed = (row_ff.in_range && !row_match && run_open_ff) ||
                                (row_ff.end_of_log &&
                                 (run_open_ff || (row_ff.in_range && row_match)));
   assign status.end_of_log   = row_ff.end_of_log;
   assign status.report_ok    = report_ok;
   assign status.avg_needed   = metric_avg && (row_count_ff != '0);
   assign status.div_last     = (div_cnt_ff == {{(DIV_CNT_W-1){1'b0}}, 1'b1});
   assign status.out_free     = out_free;

   `RWDT_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && rsp_stall) |-> !(cmd.report || cmd.summary), "waiting record overwritten")
   `RWDT_ASSERT(a_div_count, clock, reset, cmd.div_step |-> (div_cnt_ff != '0), "divider stepped past its count")
   `RWDT_ASSERT_NEXT(a_summary_clear, clock, reset, cmd.summary, rsp_valid_ff && rsp_payload_ff.last && !run_open_ff && (row_count_ff == '0), "summary did not end the log")

endmodule

`default_nettype wire

/* hdl/regime_window_dwell_tracker.sv */
// ----------------------------------------------------------------------------
// Regime window dwell tracker
// Matches logged rows against per-channel bounds, reports match runs that
// last the minimum dwell, and closes each log with a summary record.
// ----------------------------------------------------------------------------
//  channel  handshake           payload                      direction
//  req      req_valid/req_stall req_payload (row)            in
//  rsp      rsp_valid/rsp_stall rsp_payload (record)         out
//  csr      csr_valid/csr_ready csr_index, csr_data          in
//
//  A row is accepted, then evaluated; closing a run adds a close and a
//  report step. End of log adds a finish and a summary step, plus the
//  radix-2 divider in average mode (any code but peak or min) when rows matched.
//  Reset is synchronous; it clears tracking state and restores register
//  defaults. A stalled rsp holds the output register; report and summary
//  wait for it to free up. csr_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module regime_window_dwell_tracker import rwdt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rwdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rwdt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* tb/regime_window_dwell_tracker_checker.sv */
// ----------------------------------------------------------------------------
// Regime window dwell tracker checker
// Watches the row, record and register channels, keeps a mirror of the
// registers and tracking state, predicts the records each row causes and
// compares every delivered record against the oldest prediction.
// ----------------------------------------------------------------------------
module regime_window_dwell_tracker_checker import rwdt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_payload_type      req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]   csr_data,
   output int unsigned          error_count,
   output int unsigned          records_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ACC_TOP    = (longint'(1) <<< (ACC_W - 1)) - 1;
   localparam longint ACC_BOTTOM = -ACC_TOP - 1;
   localparam int     PRINT_CAP  = 60;

   // register mirror
   logic [LIMIT_W-1:0] lo_bounds, hi_bounds;
   logic [MASK_W-1:0]  active_rules, lo_checks, hi_checks;
   logic [DWELL_W-1:0] dwell_floor;
   logic [MODE_W-1:0]  agg_mode;

   // tracking state
   bit                 run_live;
   logic [TIME_W-1:0]  run_origin;
   logic [COUNT_W-1:0] hit_rows;
   longint             metric_acc;
   bit                 metric_held;
   logic [TIME_W-1:0]  dwell_sum;

   rsp_payload_type    pending_records[$];

   task automatic report(string msg);
      if (error_count < PRINT_CAP)
         $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic clear_tracking();
      run_live    = 1'b0;
      run_origin  = '0;
      hit_rows    = '0;
      metric_acc  = 0;
      metric_held = 1'b0;
      dwell_sum   = '0;
   endtask

   function automatic bit row_in_regime(req_payload_type row);
      logic signed [SAMPLE_W-1:0] smp [CHANNELS];
      logic signed [SAMPLE_W-1:0] lo, hi;
      smp[0] = row.sample_a;
      smp[1] = row.sample_b;
      smp[2] = row.sample_c;
      for (int ch = 0; ch < RULE_COUNT; ch++) begin
         lo = lo_bounds[ch*SAMPLE_W +: SAMPLE_W];
         hi = hi_bounds[ch*SAMPLE_W +: SAMPLE_W];
         if (active_rules[ch]) begin
            if (!row.sample_valid_mask[ch])
               return 1'b0;
            if (lo_checks[ch] && smp[ch] < lo)
               return 1'b0;
            if (hi_checks[ch] && smp[ch] > hi)
               return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] metric_outcome();
      longint r;
      longint divisor;
      divisor = longint'(hit_rows);
      if (agg_mode == MODE_PEAK || agg_mode == MODE_MIN)
         r = metric_held ? metric_acc : 0;
      else if (hit_rows == 0)
         r = 0;
      else
         r = metric_acc / divisor;
      if (r > 32767)
         r = 32767;
      if (r < -32768)
         r = -32768;
      return r[SAMPLE_W-1:0];
   endfunction

   // close the open run; a long enough run becomes an interval record
   task automatic close_run(logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] dur;
      logic [TIME_W:0]   total;
      rsp_payload_type   rec;
      run_live = 1'b0;
      if (t >= run_origin) begin
         dur = t - run_origin;
         if (dur >= dwell_floor) begin
            total     = dwell_sum + dur;
            dwell_sum = total[TIME_W] ? '1 : total[TIME_W-1:0];
            rec             = '0;
            rec.record_kind = KIND_INTERVAL;
            rec.start_time  = run_origin;
            rec.end_time    = t;
            pending_records = {pending_records, rec};
         end
      end
   endtask

   task automatic track_row(req_payload_type row);
      int unsigned     queued_before;
      longint          v;
      rsp_payload_type rec;
      queued_before = pending_records.size();
      if (row.in_range) begin
         if (row_in_regime(row)) begin
            if (!run_live) begin
               run_live   = 1'b1;
               run_origin = row.time_ms;
            end
            if (hit_rows != '1)
               hit_rows++;
            if (row.metric_valid) begin
               v = longint'(row.metric_sample);
               case (agg_mode)
                  MODE_PEAK: begin
                     if (!metric_held || v > metric_acc)
                        metric_acc = v;
                  end
                  MODE_MIN: begin
                     if (!metric_held || v < metric_acc)
                        metric_acc = v;
                  end
                  default: begin
                     metric_acc = metric_acc + v;
                     if (metric_acc > ACC_TOP)
                        metric_acc = ACC_TOP;
                     if (metric_acc < ACC_BOTTOM)
                        metric_acc = ACC_BOTTOM;
                  end
               endcase
               metric_held = 1'b1;
            end
         end else if (run_live) begin
            close_run(row.time_ms);
         end
      end
      if (row.end_of_log) begin
         // ignored end-of-log rows still close a trailing run
         if (run_live)
            close_run(row.time_ms);
         rec                = '0;
         rec.record_kind    = KIND_SUMMARY;
         rec.matched_rows   = hit_rows;
         rec.metric_result  = metric_outcome();
         rec.total_dwell_ms = dwell_sum;
         rec.regime_seen    = (dwell_sum != 0);
         pending_records    = {pending_records, rec};
         clear_tracking();
      end
      if (pending_records.size() > queued_before)
         pending_records[pending_records.size() - 1].last = 1'b1;
   endtask

   task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report($sformatf("%s: got %0h, expected %0h", name, got, want));
   endtask

   task automatic check_record(rsp_payload_type got);
      rsp_payload_type want;
      if (pending_records.size() == 0) begin
         report($sformatf("record with none expected: kind %0d start %0h end %0h",
                          got.record_kind, got.start_time, got.end_time));
         return;
      end
      want = pending_records.pop_front();
      compare_field("record_kind", got.record_kind, want.record_kind);
      compare_field("start_time", got.start_time, want.start_time);
      compare_field("end_time", got.end_time, want.end_time);
      compare_field("matched_rows", got.matched_rows, want.matched_rows);
      compare_field("metric_result", got.metric_result, want.metric_result);
      compare_field("total_dwell_ms", got.total_dwell_ms, want.total_dwell_ms);
      compare_field("regime_seen", got.regime_seen, want.regime_seen);
      compare_field("last", got.last, want.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         lo_bounds    = '0;
         hi_bounds    = '0;
         active_rules = '0;
         lo_checks    = '0;
         hi_checks    = '0;
         dwell_floor  = MIN_DWELL_RESET;
         agg_mode     = MODE_AVERAGE;
         clear_tracking();
         pending_records.delete();
      end else begin
         // records leave before this edge's row is predicted
         if (rsp_valid && !rsp_stall)
            check_record(rsp_payload);
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOW_LIMITS:  lo_bounds    = csr_data;
               CSR_HIGH_LIMITS: hi_bounds    = csr_data;
               CSR_RULE_ACTIVE: active_rules = csr_data[MASK_W-1:0];
               CSR_LOW_ENABLE:  lo_checks    = csr_data[MASK_W-1:0];
               CSR_HIGH_ENABLE: hi_checks    = csr_data[MASK_W-1:0];
               CSR_MIN_DWELL:   dwell_floor  = csr_data[DWELL_W-1:0];
               CSR_METRIC_MODE: agg_mode     = csr_data[MODE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            track_row(req_payload);
      end
      records_due = pending_records.size();
   end

endmodule

/* tb/regime_window_dwell_tracker_tb.sv */
// ----------------------------------------------------------------------------
// Regime window dwell tracker testbench
// Drives logged rows and register writes through directed cases, random
// logs under several idle and stall mixes and a long output hold-off; the
// checker beside the block predicts and compares every record.
// ----------------------------------------------------------------------------
module regime_window_dwell_tracker_tb import rwdt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
   localparam int unsigned CYCLE_LIMIT      = 400000;
   localparam int          SETTLE_CYCLES    = 80;
   localparam int          HOLD_CYCLES      = 400;
   localparam int          ROWS_PER_SETTING = 160;
   localparam logic [LIMIT_W-1:0] LIMITS_FLOOR = 48'h8000_8000_8000;
   localparam logic [LIMIT_W-1:0] LIMITS_CEIL  = 48'h7FFF_7FFF_7FFF;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = '0;
   logic [LIMIT_W-1:0]   csr_data    = '0;

   int unsigned mismatches;
   int unsigned records_due;
   int unsigned cycle_count = 0;
   int          idle_pct    = 0;
   int          stall_pct   = 0;
   bit          hold_on     = 1'b0;
   event        hold_go;

   // copies of the bound registers, used only to aim samples
   logic [LIMIT_W-1:0] cfg_lo = '0;
   logic [LIMIT_W-1:0] cfg_hi = '0;

   regime_window_dwell_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   regime_window_dwell_tracker_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .error_count (mismatches),
      .records_due (records_due)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // long receiver hold-off, counted on rising edges
   always begin
      @(hold_go);
      @(posedge clock);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on = 1'b0;
   end

   always @(negedge clock)
      rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);

   task automatic send_row(req_payload_type row);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= row;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (records_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic configure(logic [LIMIT_W-1:0] lo, logic [LIMIT_W-1:0] hi,
                            logic [MASK_W-1:0] act, logic [MASK_W-1:0] lo_en,
                            logic [MASK_W-1:0] hi_en, logic [DWELL_W-1:0] dwell,
                            logic [MODE_W-1:0] mode);
      cfg_lo = lo;
      cfg_hi = hi;
      csr_put(CSR_LOW_LIMITS, lo);
      csr_put(CSR_HIGH_LIMITS, hi);
      csr_put(CSR_RULE_ACTIVE, act);
      csr_put(CSR_LOW_ENABLE, lo_en);
      csr_put(CSR_HIGH_ENABLE, hi_en);
      csr_put(CSR_MIN_DWELL, dwell);
      csr_put(CSR_METRIC_MODE, mode);
      csr_valid <= 1'b0;
   endtask

   task automatic random_config();
      logic [LIMIT_W-1:0]         lo, hi;
      logic signed [SAMPLE_W-1:0] a, b, swap;
      logic [DWELL_W-1:0]         dwell;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         a = 16'($urandom);
         b = 16'($urandom);
         case ($urandom_range(9))
            0: begin
               a = 16'sh8000;
               b = 16'sh7FFF;
            end
            1: b = a;
            2: ;  // left unordered: often an empty window
            default: begin
               if (a > b) begin
                  swap = a;
                  a    = b;
                  b    = swap;
               end
            end
         endcase
         lo[ch*SAMPLE_W +: SAMPLE_W] = a;
         hi[ch*SAMPLE_W +: SAMPLE_W] = b;
      end
      case ($urandom_range(9))
         0:       dwell = '0;
         1:       dwell = '1;
         2:       dwell = 16'($urandom);
         default: dwell = 16'($urandom_range(1, 600));
      endcase
      configure(lo, hi, 3'($urandom), 3'($urandom), 3'($urandom), dwell,
                2'($urandom_range(3)));
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(int ch, bit aim_in);
      logic signed [SAMPLE_W-1:0] lo, hi, v;
      int                         span;
      lo = cfg_lo[ch*SAMPLE_W +: SAMPLE_W];
      hi = cfg_hi[ch*SAMPLE_W +: SAMPLE_W];
      case ($urandom_range(19))
         0: v = lo;
         1: v = hi;
         2: v = lo - 16'sd1;
         3: v = hi + 16'sd1;
         default: begin
            if (aim_in && lo <= hi) begin
               span = int'(hi) - int'(lo);
               v    = 16'(int'(lo) + int'($urandom_range(span)));
            end else begin
               v = 16'($urandom);
            end
         end
      endcase
      return v;
   endfunction

   function automatic req_payload_type make_row(logic [TIME_W-1:0] t, bit eol, bit aim_in);
      req_payload_type row;
      row.time_ms           = t;
      row.sample_a          = pick_sample(0, aim_in);
      row.sample_b          = pick_sample(1, aim_in);
      row.sample_c          = pick_sample(2, aim_in);
      row.sample_valid_mask = (aim_in && $urandom_range(9) != 0) ? 3'b111 : 3'($urandom);
      case ($urandom_range(9))
         0:       row.metric_sample = 16'sh8000;
         1:       row.metric_sample = 16'sh7FFF;
         default: row.metric_sample = 16'($urandom);
      endcase
      row.metric_valid = ($urandom_range(9) != 0);
      row.in_range     = ($urandom_range(11) != 0);
      row.end_of_log   = eol;
      return row;
   endfunction

   function automatic req_payload_type row_of(logic [TIME_W-1:0] t,
                                              logic signed [SAMPLE_W-1:0] a,
                                              logic signed [SAMPLE_W-1:0] b,
                                              logic signed [SAMPLE_W-1:0] c,
                                              logic [MASK_W-1:0] vmask,
                                              logic signed [SAMPLE_W-1:0] metric,
                                              bit mvalid, bit inr, bit eol);
      req_payload_type row;
      row.time_ms           = t;
      row.sample_a          = a;
      row.sample_b          = b;
      row.sample_c          = c;
      row.sample_valid_mask = vmask;
      row.metric_sample     = metric;
      row.metric_valid      = mvalid;
      row.in_range          = inr;
      row.end_of_log        = eol;
      return row;
   endfunction

   function automatic logic [TIME_W-1:0] log_origin();
      case ($urandom_range(3))
         0:       return '0;
         1:       return $urandom;
         2:       return 32'hFFFF_FFFF - $urandom_range(200000);
         default: return $urandom_range(100000);
      endcase
   endfunction

   // well-formed logs with random content; runs come from the aim flipping
   task automatic run_logs(int rows);
      logic [TIME_W-1:0] t;
      bit                aim_in;
      bit                eol;
      int                pick;
      t      = log_origin();
      aim_in = 1'b1;
      for (int i = 0; i < rows; i++) begin
         eol  = ($urandom_range(24) == 0) || (i == rows - 1 && $urandom_range(3) != 0);
         pick = $urandom_range(99);
         if (pick < 4)
            t = t - $urandom_range(1, 500);
         else if (pick < 8)
            t = t + $urandom_range(60000, 140000);
         else if (pick >= 15)
            t = t + $urandom_range(1, 300);
         if ($urandom_range(4) == 0)
            aim_in = !aim_in;
         send_row(make_row(t, eol, aim_in));
         if (eol)
            t = log_origin();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset registers: every row matches, 500 ms dwell, average
      send_row(row_of(32'd0, 16'sd0, 16'sd0, 16'sd0, 3'b000, 16'sh8000, 1, 1, 0));
      send_row(row_of(32'd499, 16'sd0, 16'sd0, 16'sd0, 3'b000, 16'sh7FFF, 1, 0, 0));
      send_row(row_of(32'd500, 16'sd0, 16'sd0, 16'sd0, 3'b000, 16'sd0, 0, 0, 1));
      send_row(row_of(32'hFFFF_FFFF, -16'sd1, -16'sd1, -16'sd1, 3'b111, 16'sd9, 0, 1, 1));
      send_row(row_of(32'd100, 16'sd0, 16'sd0, 16'sd0, 3'b000, 16'sd0, 1, 0, 1));
      send_row(row_of(32'd1000, 16'sd0, 16'sd0, 16'sd0, 3'b000, 16'sd4, 1, 1, 0));
      send_row(row_of(32'd1499, 16'sd0, 16'sd0, 16'sd0, 3'b000, 16'sd4, 1, 1, 1));
      settle();

      // full-range bounds on every channel, zero dwell, peak
      configure(LIMITS_FLOOR, LIMITS_CEIL, 3'b111, 3'b111, 3'b111, 16'd0, MODE_PEAK);
      send_row(row_of(32'd10, 16'sh8000, 16'sh7FFF, 16'sh8000, 3'b111, 16'sd5, 1, 1, 0));
      send_row(row_of(32'd20, 16'sd0, 16'sd0, 16'sd0, 3'b110, 16'sd5, 1, 1, 0));
      send_row(row_of(32'd30, 16'sd0, 16'sd0, 16'sd0, 3'b111, 16'sd7, 0, 1, 0));
      send_row(row_of(32'd25, 16'sd0, 16'sd0, 16'sd0, 3'b011, 16'sd7, 1, 1, 0));
      send_row(row_of(32'd40, 16'sd0, 16'sd0, 16'sd0, 3'b000, 16'sd0, 0, 1, 1));
      send_row(row_of(32'd50, 16'sd0, 16'sd0, 16'sd0, 3'b111, 16'sd0, 0, 1, 1));
      settle();

      // tight bounds, channel 1 upper not checked, channel 2 inactive, minimum
      configure(48'h0064_0000_FFFB, 48'h0032_0000_0005, 3'b011, 3'b111, 3'b101,
                16'hFFFF, MODE_MIN);
      send_row(row_of(32'd0, -16'sd5, 16'sd0, 16'sd0, 3'b011, -16'sd7, 1, 1, 0));
      send_row(row_of(32'd1, 16'sd5, 16'sh7FFF, 16'sd0, 3'b011, 16'sd3, 1, 1, 0));
      send_row(row_of(32'd2, 16'sd6, 16'sd0, 16'sd0, 3'b011, 16'sd3, 1, 1, 0));
      send_row(row_of(32'd3, -16'sd6, 16'sd0, 16'sd0, 3'b011, 16'sd3, 1, 1, 0));
      send_row(row_of(32'd4, 16'sd0, -16'sd1, 16'sd0, 3'b011, 16'sd3, 1, 1, 0));
      settle();
      // spare mode mid-log: the held minimum is read as a sum
      configure(48'h0064_0000_FFFB, 48'h0032_0000_0005, 3'b011, 3'b111, 3'b101,
                16'hFFFF, MODE_SPARE);
      send_row(row_of(32'd5, 16'sd0, 16'sd0, 16'sd0, 3'b011, 16'sd2, 1, 1, 1));
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 26; stall_pct = 26; end
         endcase
         for (int k = 0; k < 3; k++) begin
            if (phase == 1 && k == 0)
               configure(LIMITS_FLOOR, LIMITS_CEIL, 3'b111, 3'b111, 3'b111,
                         16'hFFFF, MODE_MIN);
            else if (phase == 2 && k == 0)
               configure('0, '0, 3'b111, 3'b111, 3'b111, 16'd0, MODE_PEAK);
            else
               random_config();
            run_logs(ROWS_PER_SETTING);
            settle();
         end
      end

      // output held off while rows keep coming: every other row closes a run
      idle_pct  = 0;
      stall_pct = 0;
      configure(LIMITS_FLOOR, LIMITS_CEIL, 3'b001, 3'b000, 3'b000, 16'd0, MODE_AVERAGE);
      -> hold_go;
      for (int i = 0; i < 60; i++)
         send_row(row_of(32'(i), 16'($urandom), 16'($urandom), 16'($urandom),
                         (i % 2 == 0) ? 3'b111 : 3'b000,
                         16'($urandom), 1, 1, i == 59));
      settle();

      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
